// ===== rtl/stepper_step_position_tracker_assert.svh =====
// assertion macros for the step position tracker
// used by the top level only, expands to nothing under SYNTHESIS
`ifndef STEPPER_STEP_POSITION_TRACKER_ASSERT_SVH
`define STEPPER_STEP_POSITION_TRACKER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked outside reset
`define SSPT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sspt assertion failed");

// next-cycle implication, checked outside reset
`define SSPT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sspt assertion failed");

`else

`define SSPT_ASSERT_IMPL(lbl, ante, cons)
`define SSPT_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/sspt_pkg.sv =====
// shared types and constants for the step position tracker
// no dependencies
`default_nettype none

package sspt_pkg;

  localparam int PHASE_W    = 12;
  localparam int PHASE_STEP = 16;
  localparam int DIV_MIN    = 16;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_START = 2'd1,
    REQ_STOP  = 2'd2,
    REQ_LOAD  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    REG_PERIOD_TOP = 2'd0,
    REG_DIVIDER    = 2'd1,
    REG_DIRECTION  = 2'd2,
    REG_TARGET     = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic step_pulse;
    logic step_taken;
    logic is_moving;
    logic pulses_on;
    logic arrived;
  } sspt_flags_t;

endpackage

`default_nettype wire

// ===== rtl/sspt_core.sv =====
// next-state logic for one item: prescaler, period counter, position and flags
// depends on sspt_pkg
`default_nettype none

module sspt_core
  import sspt_pkg::*;
#(
  parameter int POSITION_BITS = 32,
  parameter int COUNTER_BITS  = 16
) (
  input  req_t                      req,
  input  logic signed [31:0]        load_value,
  input  logic [15:0]               period_top,
  input  logic [11:0]               divider,
  input  logic                      direction_up,
  input  logic signed [31:0]        target,
  input  logic [PHASE_W-1:0]        phase,
  input  logic [COUNTER_BITS-1:0]   count,
  input  logic [POSITION_BITS-1:0]  pos,
  input  logic                      moving,
  input  logic                      running,
  output logic [PHASE_W-1:0]        phase_nxt,
  output logic [COUNTER_BITS-1:0]   count_nxt,
  output logic [POSITION_BITS-1:0]  pos_nxt,
  output sspt_flags_t               flags
);

  logic [COUNTER_BITS-1:0]  top_w;
  logic [POSITION_BITS-1:0] target_w;
  logic [POSITION_BITS-1:0] load_w;
  logic [POSITION_BITS-1:0] pos_step;
  logic [11:0]              div_eff;
  logic [PHASE_W:0]         phase_sum;
  logic                     advance;
  logic                     wrap;
  logic                     moving_nxt;
  logic                     running_nxt;
  logic                     taken;
  logic                     arrived;

  assign top_w    = COUNTER_BITS'(period_top);
  assign target_w = POSITION_BITS'(target);
  assign load_w   = POSITION_BITS'(load_value);
  assign div_eff  = (divider < 12'(DIV_MIN)) ? 12'(DIV_MIN) : divider;
  assign phase_sum = (PHASE_W + 1)'(phase) + (PHASE_W + 1)'(PHASE_STEP);
  assign advance  = phase_sum >= (PHASE_W + 1)'(div_eff);
  assign wrap     = count >= top_w;
  assign pos_step = direction_up ? pos + POSITION_BITS'(1) : pos - POSITION_BITS'(1);

  always_comb begin
    phase_nxt   = phase;
    count_nxt   = count;
    pos_nxt     = pos;
    moving_nxt  = moving;
    running_nxt = running;
    taken       = 1'b0;
    arrived     = 1'b0;
    unique case (req)
      REQ_TICK: begin
        if (running) begin
          phase_nxt = advance ? PHASE_W'(phase_sum - (PHASE_W + 1)'(div_eff))
                              : phase_sum[PHASE_W-1:0];
          if (advance) begin
            if (wrap) begin
              count_nxt  = '0;
              taken      = 1'b1;
              pos_nxt    = pos_step;
              moving_nxt = 1'b1;
              if (pos_step == target_w) begin
                running_nxt = 1'b0;
                moving_nxt  = 1'b0;
                arrived     = 1'b1;
              end
            end else begin
              count_nxt = count + COUNTER_BITS'(1);
            end
          end
        end
      end
      REQ_START: begin
        moving_nxt  = 1'b1;
        running_nxt = 1'b1;
      end
      REQ_STOP: begin
        // stopping off target only pauses, motion stays pending
        running_nxt = 1'b0;
        moving_nxt  = (pos != target_w);
      end
      REQ_LOAD: begin
        pos_nxt = load_w;
      end
      default: begin
        pos_nxt = pos;
      end
    endcase
  end

  always_comb begin
    flags.step_pulse = count_nxt < (top_w >> 1);
    flags.step_taken = taken;
    flags.is_moving  = moving_nxt;
    flags.pulses_on  = running_nxt;
    flags.arrived    = arrived;
  end

endmodule

`default_nettype wire

// ===== rtl/stepper_step_position_tracker.sv =====
// Step pulse generator with signed position counter. Each accepted item is one
// system tick or a command (start, stop, load position) and gives exactly one
// result item. Throughput is one item per clock unless out_ready stalls results:
// the prescaler, period counter and position state close their loop in a single
// update stage, fed by an input register and feeding a result register; an item
// passes the input register and then the result register. While a result waits,
// one more item is taken into the input register and then in_ready drops until
// the result leaves. Registers sit on
// an APB port at byte addresses 0, 4, 8, 12 (period top, divider in sixteenths,
// direction, target); write them only while no item is in flight.
// depends on sspt_pkg, sspt_core and stepper_step_position_tracker_assert.svh
`default_nettype none

`include "stepper_step_position_tracker_assert.svh"

module stepper_step_position_tracker
  import sspt_pkg::*;
#(
  parameter int POSITION_BITS = 32,
  parameter int COUNTER_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_req_type,
  input  logic signed [31:0] in_load_value,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_step_pulse,
  output logic               out_step_taken,
  output logic signed [31:0] out_position_now,
  output logic               out_is_moving,
  output logic               out_pulses_on,
  output logic               out_arrived,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // configuration registers
  logic [15:0]               period_top_r;
  logic [11:0]               divider_r;
  logic                      direction_up_r;
  logic signed [31:0]        target_r;

  // input register
  logic                      in_valid_r;
  req_t                      in_req_r;
  logic signed [31:0]        in_load_r;

  // block state
  logic [PHASE_W-1:0]        phase_r;
  logic [COUNTER_BITS-1:0]   count_r;
  logic [POSITION_BITS-1:0]  pos_r;
  logic                      moving_r;
  logic                      running_r;

  // result register
  logic                      out_valid_r;
  sspt_flags_t               out_flags_r;
  logic [31:0]               out_pos_r;

  logic [PHASE_W-1:0]        phase_nxt;
  logic [COUNTER_BITS-1:0]   count_nxt;
  logic [POSITION_BITS-1:0]  pos_nxt;
  sspt_flags_t               flags_nxt;
  logic                      advance;
  logic                      cfg_wr;
  reg_idx_t                  reg_idx;

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign reg_idx  = reg_idx_t'(paddr[3:2]);
  assign pready   = 1'b1;

  always_comb begin
    unique case (reg_idx)
      REG_PERIOD_TOP: prdata = 32'(period_top_r);
      REG_DIVIDER:    prdata = 32'(divider_r);
      REG_DIRECTION:  prdata = 32'(direction_up_r);
      REG_TARGET:     prdata = target_r;
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_top_r   <= 16'hFFFF;
      divider_r      <= 12'(DIV_MIN);
      direction_up_r <= 1'b1;
      target_r       <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_PERIOD_TOP: period_top_r   <= pwdata[15:0];
        REG_DIVIDER:    divider_r      <= pwdata[11:0];
        REG_DIRECTION:  direction_up_r <= pwdata[0];
        REG_TARGET:     target_r       <= pwdata;
        default:        target_r       <= target_r;
      endcase
    end
  end

  sspt_core #(
    .POSITION_BITS (POSITION_BITS),
    .COUNTER_BITS  (COUNTER_BITS)
  ) u_core (
    .req          (in_req_r),
    .load_value   (in_load_r),
    .period_top   (period_top_r),
    .divider      (divider_r),
    .direction_up (direction_up_r),
    .target       (target_r),
    .phase        (phase_r),
    .count        (count_r),
    .pos          (pos_r),
    .moving       (moving_r),
    .running      (running_r),
    .phase_nxt    (phase_nxt),
    .count_nxt    (count_nxt),
    .pos_nxt      (pos_nxt),
    .flags        (flags_nxt)
  );

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_req_r  <= req_t'(in_req_type);
      in_load_r <= in_load_value;
    end
    if (advance) begin
      out_flags_r <= flags_nxt;
      out_pos_r   <= 32'(pos_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= '0;
      count_r     <= '0;
      pos_r       <= '0;
      moving_r    <= 1'b0;
      running_r   <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        phase_r     <= phase_nxt;
        count_r     <= count_nxt;
        pos_r       <= pos_nxt;
        moving_r    <= flags_nxt.is_moving;
        running_r   <= flags_nxt.pulses_on;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_step_pulse   = out_flags_r.step_pulse;
  assign out_step_taken   = out_flags_r.step_taken;
  assign out_position_now = out_pos_r;
  assign out_is_moving    = out_flags_r.is_moving;
  assign out_pulses_on    = out_flags_r.pulses_on;
  assign out_arrived      = out_flags_r.arrived;

  // counter never runs without a pending move
  `SSPT_ASSERT_IMPL(a_running_implies_moving, running_r, moving_r)
  // arrival shuts everything off in the same item
  `SSPT_ASSERT_IMPL(a_arrived_stops, out_valid_r && out_flags_r.arrived,
                    !out_flags_r.is_moving && !out_flags_r.pulses_on)
  // a held item stays in the input register until the update stage takes it
  `SSPT_ASSERT_NEXT(a_input_held, in_valid_r && !advance, in_valid_r && $stable(in_req_r))
  // a step with no arrival keeps the counter running
  `SSPT_ASSERT_IMPL(a_step_keeps_running,
                    out_valid_r && out_flags_r.step_taken && !out_flags_r.arrived,
                    out_flags_r.pulses_on && out_flags_r.is_moving)

endmodule

`default_nettype wire

// ===== tb/sspt_position_checker.sv =====
// passive checker for the step position tracker: follows the register port and both item
// channels, predicts every result from its own copy of the tracker state and compares.
// depends on sspt_pkg
module sspt_position_checker
  import sspt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_load_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_step_pulse,
  input  logic        out_step_taken,
  input  logic [31:0] out_position_now,
  input  logic        out_is_moving,
  input  logic        out_pulses_on,
  input  logic        out_arrived,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          error_count,
  output int          results_owed
);

  typedef struct packed {
    logic        step_pulse;
    logic        step_taken;
    logic [31:0] position;
    logic        moving;
    logic        running;
    logic        arrived;
  } tracker_result_t;

  // register copies
  logic [15:0] top_r;
  logic [11:0] div_r;
  logic        dir_up_r;
  logic [31:0] target_r;

  // tracker state
  logic [11:0] trk_phase;
  logic [15:0] trk_count;
  logic [31:0] trk_pos;
  logic        trk_moving;
  logic        trk_running;

  tracker_result_t owed_results[$];

  initial begin
    error_count  = 0;
    results_owed = 0;
  end

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] seen);
    if (want !== seen) begin
      error_count++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, seen);
    end
  endtask

  always @(posedge clk) begin
    tracker_result_t nxt;
    tracker_result_t want;
    int              psum;
    int              div_eff;
    logic            advance;
    logic            taken;
    logic            hit;

    if (!rst_n) begin
      top_r       = 16'hFFFF;
      div_r       = 12'd16;
      dir_up_r    = 1'b1;
      target_r    = '0;
      trk_phase   = '0;
      trk_count   = '0;
      trk_pos     = '0;
      trk_moving  = 1'b0;
      trk_running = 1'b0;
      owed_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_PERIOD_TOP: top_r    = pwdata[15:0];
          REG_DIVIDER:    div_r    = pwdata[11:0];
          REG_DIRECTION:  dir_up_r = pwdata[0];
          REG_TARGET:     target_r = pwdata;
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          error_count++;
          $display("%0t: result item with nothing expected, position %h", $time,
                   out_position_now);
        end else begin
          want = owed_results.pop_front();
          check_field("step_pulse", want.step_pulse, out_step_pulse);
          check_field("step_taken", want.step_taken, out_step_taken);
          check_field("position_now", want.position, out_position_now);
          check_field("is_moving", want.moving, out_is_moving);
          check_field("pulses_on", want.running, out_pulses_on);
          check_field("arrived", want.arrived, out_arrived);
        end
      end

      if (in_valid && in_ready) begin
        taken = 1'b0;
        hit   = 1'b0;
        case (req_t'(in_req_type))
          REQ_TICK: begin
            if (trk_running) begin
              div_eff = (div_r < DIV_MIN) ? DIV_MIN : int'(div_r);
              psum    = int'(trk_phase) + PHASE_STEP;
              advance = 1'b0;
              if (psum >= div_eff) begin
                psum    = psum - div_eff;
                advance = 1'b1;
              end
              trk_phase = 12'(psum);
              if (advance) begin
                // a count already at or past top wraps, top of zero included
                if (trk_count >= top_r) begin
                  trk_count = '0;
                  taken     = 1'b1;
                end else begin
                  trk_count = trk_count + 16'd1;
                end
              end
              if (taken) begin
                trk_pos    = dir_up_r ? trk_pos + 32'd1 : trk_pos - 32'd1;
                trk_moving = 1'b1;
                if (trk_pos == target_r) begin
                  trk_running = 1'b0;
                  trk_moving  = 1'b0;
                  hit         = 1'b1;
                end
              end
            end
          end
          REQ_START: begin
            trk_moving  = 1'b1;
            trk_running = 1'b1;
          end
          REQ_STOP: begin
            // stop away from the target only pauses, motion stays flagged
            trk_moving  = (trk_pos != target_r);
            trk_running = 1'b0;
          end
          REQ_LOAD: trk_pos = in_load_value;
          default: ;
        endcase
        nxt.step_pulse = (trk_count < (top_r >> 1));
        nxt.step_taken = taken;
        nxt.position   = trk_pos;
        nxt.moving     = trk_moving;
        nxt.running    = trk_running;
        nxt.arrived    = hit;
        owed_results.push_back(nxt);
      end
    end
    results_owed <= owed_results.size();
  end

endmodule

// ===== tb/tb_stepper_step_position_tracker.sv =====
// testbench top for the step position tracker: clock, reset, register writes and item
// stimulus with random idling on both channels, plus the final verdict.
// depends on sspt_pkg, stepper_step_position_tracker and sspt_position_checker
module tb_stepper_step_position_tracker;
  import sspt_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int PHASE_COUNT  = 14;
  localparam int PHASE_ITEMS  = 64;
  localparam int TICK_CAP     = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_req_type = REQ_TICK;
  logic [31:0] in_load_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_step_pulse;
  logic        out_step_taken;
  logic [31:0] out_position_now;
  logic        out_is_moving;
  logic        out_pulses_on;
  logic        out_arrived;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int          error_count;
  int          results_owed;
  int          cycle_count = 0;
  int          ready_hold = 0;
  int          items_sent = 0;
  bit          gaps_on = 1'b0;

  // planning copy of the registers, used to size tick runs
  int unsigned cur_top = 65535;
  int unsigned cur_div = 16;
  logic        cur_dir = 1'b1;
  logic [31:0] cur_target = '0;

  stepper_step_position_tracker dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_load_value    (in_load_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_step_pulse   (out_step_pulse),
    .out_step_taken   (out_step_taken),
    .out_position_now (out_position_now),
    .out_is_moving    (out_is_moving),
    .out_pulses_on    (out_pulses_on),
    .out_arrived      (out_arrived),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  sspt_position_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_load_value    (in_load_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_step_pulse   (out_step_pulse),
    .out_step_taken   (out_step_taken),
    .out_position_now (out_position_now),
    .out_is_moving    (out_is_moving),
    .out_pulses_on    (out_pulses_on),
    .out_arrived      (out_arrived),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .error_count      (error_count),
    .results_owed     (results_owed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side back-pressure: mostly short stalls, a few long ones
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (!gaps_on) begin
      out_ready <= 1'b1;
    end else if (r < 65) begin
      out_ready  <= 1'b1;
      ready_hold <= $urandom_range(0, 7);
    end else if (r < 95) begin
      out_ready  <= 1'b0;
      ready_hold <= $urandom_range(0, 2);
    end else begin
      out_ready  <= 1'b0;
      ready_hold <= $urandom_range(9, 29);
    end
  end

  task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
    case (idx)
      REG_PERIOD_TOP: cur_top = val[15:0];
      REG_DIVIDER:    cur_div = val[11:0];
      REG_DIRECTION:  cur_dir = val[0];
      REG_TARGET:     cur_target = val;
      default: ;
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // valid stays high into the next item when there is no gap
  task automatic send(input req_t req, input logic [31:0] val);
    int r;
    int gap;
    r   = $urandom_range(0, 99);
    gap = 0;
    if (gaps_on) begin
      if (r >= 95) gap = $urandom_range(8, 30);
      else if (r >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_load_value <= val;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // hold off until every result is back, then let the pipeline drain
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (4) @(posedge clk);
  endtask

  // load a few steps short of the target, start, and tick toward it, capped at TICK_CAP ticks
  task automatic approach_target();
    int          k;
    int          n;
    int unsigned dv;
    k  = $urandom_range(1, 4);
    dv = (cur_div < DIV_MIN) ? DIV_MIN : cur_div;
    send(REQ_LOAD, cur_dir ? cur_target - 32'(k) : cur_target + 32'(k));
    send(REQ_START, $urandom);
    n = k * (cur_top + 1) * ((dv + 15) / 16) + $urandom_range(0, 3);
    if (n > TICK_CAP) n = TICK_CAP;
    repeat (n) send(REQ_TICK, $urandom);
    if ($urandom_range(0, 1) == 1) send(REQ_STOP, $urandom);
  endtask

  initial begin
    int pick;
    int phase_end;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: wrap through the largest positive position onto a target at the minimum
    reg_write(REG_PERIOD_TOP, 32'd3);
    reg_write(REG_DIVIDER, 32'd16);
    reg_write(REG_DIRECTION, 32'd1);
    reg_write(REG_TARGET, 32'h8000_0000);
    send(REQ_TICK, 32'h0);
    send(REQ_START, 32'h0);
    send(REQ_LOAD, 32'h7FFF_FFFE);
    repeat (8) send(REQ_TICK, 32'h0);
    send(REQ_TICK, 32'hFFFF_FFFF);
    send(REQ_STOP, 32'h0);
    send(REQ_LOAD, 32'hFFFF_FFFF);
    send(REQ_START, 32'hFFFF_FFFF);
    repeat (2) send(REQ_TICK, 32'h0);
    send(REQ_STOP, 32'h0);
    send(REQ_TICK, 32'h0);
    send(REQ_LOAD, 32'h5555_5555);
    send(REQ_LOAD, 32'hAAAA_AAAA);
    send(REQ_LOAD, 32'h0);

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      settle();
      gaps_on = ($urandom_range(0, 3) != 0);
      case (ph)
        0: begin
          reg_write(REG_PERIOD_TOP, 32'd65535);
          reg_write(REG_DIVIDER, 32'd16);
          reg_write(REG_DIRECTION, 32'd1);
          reg_write(REG_TARGET, $urandom);
        end
        1: begin
          // count left high by the last phase now sits above a zero top
          reg_write(REG_PERIOD_TOP, 32'd0);
          reg_write(REG_DIVIDER, 32'd0);
          reg_write(REG_DIRECTION, 32'd0);
          reg_write(REG_TARGET, 32'h7FFF_FFFF);
        end
        2: begin
          reg_write(REG_PERIOD_TOP, 32'd1);
          reg_write(REG_DIVIDER, 32'd15);
          reg_write(REG_DIRECTION, 32'd1);
          reg_write(REG_TARGET, 32'h8000_0000);
        end
        3: begin
          reg_write(REG_PERIOD_TOP, 32'd2);
          reg_write(REG_DIVIDER, 32'd4095);
          reg_write(REG_DIRECTION, 32'd0);
          reg_write(REG_TARGET, $urandom);
        end
        default: begin
          reg_write(REG_PERIOD_TOP, $urandom_range(1, 10));
          if ($urandom_range(0, 3) != 0)
            reg_write(REG_DIVIDER, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095)
                                                               : $urandom_range(16, 40));
          if ($urandom_range(0, 3) != 0) reg_write(REG_DIRECTION, $urandom_range(0, 1));
          if ($urandom_range(0, 3) != 0) reg_write(REG_TARGET, $urandom);
        end
      endcase

      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          approach_target();
        end else if (pick < 8) begin
          send(REQ_START, $urandom);
          repeat ($urandom_range(1, 20)) send(REQ_TICK, $urandom);
          send(REQ_STOP, $urandom);
        end else begin
          send(req_t'(2'($urandom_range(0, 3))), $urandom);
        end
      end
    end

    settle();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/sspt_pkg.sv
rtl/sspt_core.sv
rtl/stepper_step_position_tracker.sv
tb/sspt_position_checker.sv
tb/tb_stepper_step_position_tracker.sv
